>>> design/lrg_pkg.sv
package lrg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 17;
  localparam int PHASE_W  = 24;

  localparam logic [RATE_W-1:0] IN_RATE_RESET  = 17'd22050;
  localparam logic [RATE_W-1:0] OUT_RATE_RESET = 17'd16000;
  localparam logic [RATE_W-1:0] GAIN_RESET     = 17'd65536;

  // configuration register indexes
  localparam logic [1:0] REG_IN_RATE  = 2'd0;
  localparam logic [1:0] REG_OUT_RATE = 2'd1;
  localparam logic [1:0] REG_GAIN     = 2'd2;

  localparam int          QUEUE_DEPTH = 4;
  localparam logic [3:0]  MAX_RES     = 4'd8;

  // serial divider step counts
  localparam logic [4:0] DIV_INTERP_STEPS = 5'd16;
  localparam logic [4:0] DIV_SKIP_STEPS   = 5'd24;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } q_item_t;

  typedef struct packed {
    logic               start;
    logic [RATE_W-1:0]  divisor;
    logic [RATE_W-1:0]  rem_init;
    logic [PHASE_W-1:0] bits;
    logic [4:0]         steps;
  } div_req_t;

  typedef struct packed {
    logic       idle;
    logic       pend_valid;
    logic [3:0] n;
  } back_stat_t;

endpackage

>>> design/lrg_fifo.sv
module lrg_fifo #(
  parameter int DEPTH = lrg_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lrg_pkg::q_item_t wdata,
  output logic             full,
  input  logic             pop,
  output lrg_pkg::q_item_t rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lrg_pkg::q_item_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/lrg_front.sv
module lrg_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [lrg_pkg::SAMPLE_W-1:0] s_axis_tdata,
  input  logic                         s_axis_tlast,
  input  logic [lrg_pkg::RATE_W-1:0]   gain,
  input  logic                         q_full,
  output logic                         q_push,
  output lrg_pkg::q_item_t             q_wdata
);

  logic                                st_valid;
  logic signed [32:0]                  st_prod;
  logic                                st_unity;
  logic signed [lrg_pkg::SAMPLE_W-1:0] st_raw;
  logic                                st_last;
  logic signed [32:0]                  rounded;

  assign q_push        = st_valid && !q_full;
  assign s_axis_tready = !st_valid || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s_axis_tready) begin
      st_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      st_prod  <= $signed(s_axis_tdata) * $signed({1'b0, gain[15:0]});
      st_unity <= gain[16];
      st_raw   <= $signed(s_axis_tdata);
      st_last  <= s_axis_tlast;
    end
  end

  // round toward zero before the arithmetic shift
  always_comb begin
    rounded = st_prod + (st_prod[32] ? 33'sd65535 : 33'sd0);
    q_wdata.last   = st_last;
    q_wdata.sample = st_unity ? st_raw : rounded[31:16];
  end

endmodule

>>> design/lrg_div.sv
module lrg_div (
  input  logic                       clk,
  input  logic                       rst,
  input  lrg_pkg::div_req_t          req,
  output logic                       done,
  output logic [15:0]                quot,
  output logic [lrg_pkg::RATE_W-1:0] rem
);

  logic                               busy;
  logic [4:0]                         cnt;
  logic [lrg_pkg::PHASE_W-1:0]        sh;
  logic [lrg_pkg::RATE_W-1:0]         divisor;
  logic [lrg_pkg::RATE_W:0]           trial;
  logic                               fits;

  always_comb begin
    trial = {rem, sh[lrg_pkg::PHASE_W-1]};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && cnt == 5'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt     <= req.steps;
      sh      <= req.bits;
      rem     <= req.rem_init;
      divisor <= req.divisor;
      quot    <= '0;
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      sh   <= {sh[lrg_pkg::PHASE_W-2:0], 1'b0};
      quot <= {quot[14:0], fits};
      rem  <= fits ? lrg_pkg::RATE_W'(trial - {1'b0, divisor}) : trial[lrg_pkg::RATE_W-1:0];
    end
  end

endmodule

>>> design/lrg_back.sv
module lrg_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lrg_pkg::RATE_W-1:0]   ir,
  input  logic [lrg_pkg::RATE_W-1:0]   orr,
  input  logic                         item_valid,
  input  lrg_pkg::q_item_t             item,
  output logic                         pop,
  output lrg_pkg::div_req_t            div_req,
  input  logic                         div_done,
  input  logic [15:0]                  div_quot,
  input  logic [lrg_pkg::RATE_W-1:0]   div_rem,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [lrg_pkg::SAMPLE_W-1:0] m_axis_tdata,
  output logic                         m_axis_tlast,
  output lrg_pkg::back_stat_t          stat
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOOP  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_SUM   = 4'd3;
  localparam logic [3:0] ST_DIVW  = 4'd4;
  localparam logic [3:0] ST_EMIT  = 4'd5;
  localparam logic [3:0] ST_SKIP  = 4'd6;
  localparam logic [3:0] ST_SKIPW = 4'd7;
  localparam logic [3:0] ST_POST  = 4'd8;
  localparam logic [3:0] ST_TAIL  = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  localparam int PW = lrg_pkg::PHASE_W;
  localparam int SW = lrg_pkg::SAMPLE_W;

  logic [3:0]           state;
  logic signed [PW-1:0] phase;
  logic signed [SW-1:0] prev;
  logic                 chunk_start;
  logic signed [SW-1:0] cur_s;
  logic                 cur_last;
  logic [3:0]           n;
  logic signed [33:0]   prod_a;
  logic signed [33:0]   prod_b;
  logic                 q_neg;
  logic signed [SW-1:0] emit_val;
  logic                 from_tail;
  logic signed [SW-1:0] pend_val;
  logic                 pend_valid;

  logic signed [PW-1:0] ir_s;
  logic signed [PW-1:0] orr_s;
  logic signed [PW-1:0] p_plus_ir;
  logic signed [PW-1:0] neg_p;
  logic signed [PW-1:0] r;
  logic signed [34:0]   a_sum;
  logic [34:0]          a_mag;
  logic                 out_free;
  logic                 out_load;

  always_comb begin
    ir_s      = $signed({7'd0, ir});
    orr_s     = $signed({7'd0, orr});
    p_plus_ir = phase + ir_s;
    neg_p     = -phase;
    r         = phase + orr_s;
    a_sum     = 35'(prod_a) + 35'(prod_b);
    a_mag     = a_sum[34] ? 35'(-a_sum) : 35'(a_sum);
    out_free  = !m_axis_tvalid || m_axis_tready;
    out_load  = pend_valid && out_free && ((state == ST_EMIT) || (state == ST_FIN));
    pop       = (state == ST_IDLE) && item_valid;

    div_req = '0;
    case (state)
      ST_SUM: begin
        div_req.start    = 1'b1;
        div_req.divisor  = orr;
        div_req.rem_init = a_mag[32:16];
        div_req.bits     = {a_mag[15:0], 8'd0};
        div_req.steps    = lrg_pkg::DIV_INTERP_STEPS;
      end
      ST_SKIP: begin
        div_req.start    = 1'b1;
        div_req.divisor  = ir;
        div_req.bits     = neg_p;
        div_req.steps    = lrg_pkg::DIV_SKIP_STEPS;
      end
      default: begin
        div_req = '0;
      end
    endcase

    stat.idle       = (state == ST_IDLE);
    stat.pend_valid = pend_valid;
    stat.n          = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= '0;
      prev          <= '0;
      chunk_start   <= 1'b1;
      n             <= '0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cur_s    <= item.sample;
            cur_last <= item.last;
            n        <= '0;
            state    <= chunk_start ? ST_POST : ST_LOOP;
          end
        end
        ST_LOOP: begin
          if (!phase[PW-1]) begin
            state <= ST_POST;
          end else if (cur_last && (p_plus_ir > orr_s)) begin
            state <= ST_POST;
          end else if (n == lrg_pkg::MAX_RES) begin
            state <= cur_last ? ST_POST : ST_SKIP;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_a <= prev * $signed(neg_p[17:0]);
          prod_b <= cur_s * $signed(r[17:0]);
          state  <= ST_SUM;
        end
        ST_SUM: begin
          q_neg <= a_sum[34];
          state <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) begin
            emit_val  <= q_neg ? $signed(-div_quot) : $signed(div_quot);
            from_tail <= 1'b0;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // hold the newest result back until we know whether it ends the run
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              m_axis_tdata <= pend_val;
              m_axis_tlast <= 1'b0;
            end
            pend_val   <= emit_val;
            pend_valid <= 1'b1;
            phase      <= p_plus_ir;
            n          <= n + 1'b1;
            state      <= from_tail ? ST_TAIL : ST_LOOP;
          end
        end
        ST_SKIP: begin
          state <= ST_SKIPW;
        end
        ST_SKIPW: begin
          // advance phase to the first step at or past zero
          if (div_done) begin
            phase <= (div_rem == '0) ? '0 : ir_s - $signed({7'd0, div_rem});
            state <= ST_POST;
          end
        end
        ST_POST: begin
          phase       <= phase - orr_s;
          prev        <= cur_s;
          chunk_start <= 1'b0;
          state       <= cur_last ? ST_TAIL : ST_FIN;
        end
        ST_TAIL: begin
          if ((p_plus_ir <= $signed(24'd0)) && (n < lrg_pkg::MAX_RES)) begin
            emit_val  <= cur_s;
            from_tail <= 1'b1;
            state     <= ST_EMIT;
          end else begin
            phase       <= '0;
            chunk_start <= 1'b1;
            state       <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            m_axis_tdata <= pend_val;
            m_axis_tlast <= 1'b1;
            pend_valid   <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/linear_resampler_with_gain_core.sv
// Linear-interpolation resampler with gain for 16-bit mono PCM.
// Input beats arrive on s_axis: tdata is the sample, tlast closes a chunk.
// Each sample is scaled by gain (unsigned Q1.16, clamped to unity) and the
// stream is resampled from in_rate to out_rate; phase restarts after every
// chunk, and a chunk's last sample flushes its tail outputs.
// Output beats leave on m_axis: tdata is the resampled sample, tlast marks
// the last output caused by one input beat. An input may cause no output.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
// (in_rate, out_rate, gain); write only while the block is idle.
// Flow: the front stage takes a beat every cycle while the four-entry queue
// has room. The back sequencer computes each interpolated output with a
// 16-step serial divide on out_rate; a tail output needs no divide. When
// more than 8 outputs fall on one sample, the phase skip adds a 24-step
// remainder divide on in_rate. An output leaves only once the next result
// of its sample is ready or the sample is finished, since a result is held
// until the next one shows whether it ends the run.
// Reset restores the default rates and unity gain, clears the phase and
// empties the queue. When m_axis stalls, the back part holds and the queue
// fills, after which s_axis_tready drops; nothing is lost.
module linear_resampler_with_gain_core #(
  parameter int QUEUE_DEPTH = lrg_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] out_sample
  output logic        m_axis_tlast,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);

  logic [lrg_pkg::RATE_W-1:0] in_rate;
  logic [lrg_pkg::RATE_W-1:0] out_rate;
  logic [lrg_pkg::RATE_W-1:0] gain;
  logic [lrg_pkg::RATE_W-1:0] ir_eff;
  logic [lrg_pkg::RATE_W-1:0] orr_eff;

  logic                       q_push;
  logic                       q_full;
  logic                       q_empty;
  logic                       q_pop;
  lrg_pkg::q_item_t           q_wdata;
  lrg_pkg::q_item_t           q_rdata;
  lrg_pkg::div_req_t          div_req;
  logic                       div_done;
  logic [15:0]                div_quot;
  logic [lrg_pkg::RATE_W-1:0] div_rem;
  lrg_pkg::back_stat_t        stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_rate  <= lrg_pkg::IN_RATE_RESET;
      out_rate <= lrg_pkg::OUT_RATE_RESET;
      gain     <= lrg_pkg::GAIN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lrg_pkg::REG_IN_RATE:  in_rate  <= cfg_wdata;
        lrg_pkg::REG_OUT_RATE: out_rate <= cfg_wdata;
        lrg_pkg::REG_GAIN:     gain     <= cfg_wdata;
        default: begin
          in_rate <= in_rate;
        end
      endcase
    end
  end

  // a zero rate acts as one
  assign ir_eff  = (in_rate == '0) ? 17'd1 : in_rate;
  assign orr_eff = (out_rate == '0) ? 17'd1 : out_rate;

  lrg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .gain          (gain),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  lrg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  lrg_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  lrg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .ir            (ir_eff),
    .orr           (orr_eff),
    .item_valid    (!q_empty),
    .item          (q_rdata),
    .pop           (q_pop),
    .div_req       (div_req),
    .div_done      (div_done),
    .div_quot      (div_quot),
    .div_rem       (div_rem),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .stat          (stat)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("queue written while full");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    stat.n <= lrg_pkg::MAX_RES)
    else $error("more results than allowed for one sample");

  a_idle_flushed: assert property (@(posedge clk) disable iff (rst)
    stat.idle |-> !stat.pend_valid)
    else $error("held result left behind when sequencer went idle");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

>>> tb/tb_linear_resampler_with_gain_core.sv
module tb_linear_resampler_with_gain_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [lrg_pkg::SAMPLE_W-1:0] value;
    logic                                tail;
  } pcm_out_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                           kind;
    logic signed [lrg_pkg::SAMPLE_W-1:0] smp;
    logic                                lst;
    int                                  n_typed;
    logic signed [lrg_pkg::SAMPLE_W-1:0] v0;
    logic signed [lrg_pkg::SAMPLE_W-1:0] v1;
    logic [lrg_pkg::RATE_W-1:0]          in_r;
    logic [lrg_pkg::RATE_W-1:0]          out_r;
    logic [lrg_pkg::RATE_W-1:0]          gn;
  } dir_row_t;

  localparam int     BY_MODEL       = -1;
  localparam int     SETTLE_CYCLES  = 200;
  localparam int     PHASES         = 6;
  localparam int     ITEMS_PER_PH   = 14;
  localparam longint UNITY_GAIN     = 65536;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata   = '0;
  logic                s_axis_tlast   = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [15:0]         m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_wr_en      = 1'b0;
  logic [1:0]          cfg_index      = lrg_pkg::REG_IN_RATE;
  logic [16:0]         cfg_wdata      = '0;

  // shadow of the block's registers and resampler state
  logic [lrg_pkg::RATE_W-1:0]          in_rate_q  = lrg_pkg::IN_RATE_RESET;
  logic [lrg_pkg::RATE_W-1:0]          out_rate_q = lrg_pkg::OUT_RATE_RESET;
  logic [lrg_pkg::RATE_W-1:0]          gain_q     = lrg_pkg::GAIN_RESET;
  logic signed [lrg_pkg::SAMPLE_W-1:0] held_smp   = '0;
  logic signed [lrg_pkg::PHASE_W-1:0]  phase_acc  = '0;
  logic                                chunk_open = 1'b1;

  pcm_out_t expected_q[$];
  dir_row_t dir_tab[$];
  int       mismatch_cnt   = 0;
  int       src_idle_pct   = 0;
  int       sink_stall_pct = 0;

  logic [15:0] rail_vals[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
  int          src_mode[PHASES]  = '{0, 80, 0, 18, 0, 18};
  int          sink_mode[PHASES] = '{0, 0, 80, 18, 80, 0};

  always #1 clk = ~clk;

  linear_resampler_with_gain_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // Scale one sample, emit the interpolated points that fall before it and,
  // on a chunk close, the tail points; returns how many were produced.
  function automatic int resample_step(input logic signed [lrg_pkg::SAMPLE_W-1:0] din,
                                       input logic din_last,
                                       output pcm_out_t res [8]);
    longint s;
    longint g;
    longint ir;
    longint orr;
    longint p;
    longint r;
    longint acc;
    int     n;
    s   = longint'(din);
    g   = (longint'(gain_q) > UNITY_GAIN) ? UNITY_GAIN : longint'(gain_q);
    ir  = (in_rate_q == '0) ? 1 : longint'(in_rate_q);
    orr = (out_rate_q == '0) ? 1 : longint'(out_rate_q);
    p   = longint'(phase_acc);
    n   = 0;
    foreach (res[k]) res[k] = '0;
    if (g < UNITY_GAIN) s = (s * g) / UNITY_GAIN;
    if (!chunk_open) begin
      while (p < 0) begin
        if (din_last && p + ir > orr) break;
        if (n >= int'(lrg_pkg::MAX_RES)) begin
          // drop the excess points and, unless the chunk closes here, move the phase past them
          if (!din_last) p += ir * ((-p + ir - 1) / ir);
          break;
        end
        r   = p + orr;
        acc = longint'(held_smp) * (orr - r) + s * r;
        res[n].value = 16'(acc / orr);
        n++;
        p += ir;
      end
    end
    p -= orr;
    held_smp   = 16'(s);
    chunk_open = 1'b0;
    if (din_last) begin
      while (p + ir <= 0 && n < int'(lrg_pkg::MAX_RES)) begin
        res[n].value = 16'(s);
        n++;
        p += ir;
      end
      p          = 0;
      chunk_open = 1'b1;
    end
    phase_acc = 24'(p);
    if (n > 0) res[n-1].tail = 1'b1;
    return n;
  endfunction

  function automatic void add_beat(input logic signed [lrg_pkg::SAMPLE_W-1:0] smp,
                                   input logic lst,
                                   input int n_typed,
                                   input logic signed [lrg_pkg::SAMPLE_W-1:0] v0,
                                   input logic signed [lrg_pkg::SAMPLE_W-1:0] v1);
    dir_row_t row;
    row.kind    = ROW_BEAT;
    row.smp     = smp;
    row.lst     = lst;
    row.n_typed = n_typed;
    row.v0      = v0;
    row.v1      = v1;
    row.in_r    = '0;
    row.out_r   = '0;
    row.gn      = '0;
    dir_tab     = {dir_tab, row};
  endfunction

  function automatic void add_cfg(input logic [lrg_pkg::RATE_W-1:0] in_r,
                                  input logic [lrg_pkg::RATE_W-1:0] out_r,
                                  input logic [lrg_pkg::RATE_W-1:0] gn);
    dir_row_t row;
    row.kind    = ROW_CFG;
    row.smp     = '0;
    row.lst     = 1'b0;
    row.n_typed = BY_MODEL;
    row.v0      = '0;
    row.v1      = '0;
    row.in_r    = in_r;
    row.out_r   = out_r;
    row.gn      = gn;
    dir_tab     = {dir_tab, row};
  endfunction

  task automatic send_sample(input logic signed [lrg_pkg::SAMPLE_W-1:0] smp,
                             input logic lst,
                             input int n_typed,
                             input logic signed [lrg_pkg::SAMPLE_W-1:0] v0,
                             input logic signed [lrg_pkg::SAMPLE_W-1:0] v1);
    pcm_out_t got [8];
    pcm_out_t one;
    int       n;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
    n = resample_step(smp, lst, got);
    if (n_typed == BY_MODEL) begin
      for (int k = 0; k < n; k++) expected_q = {expected_q, got[k]};
    end else begin
      for (int k = 0; k < n_typed; k++) begin
        one.value  = (k == 0) ? v0 : v1;
        one.tail   = (k == n_typed - 1);
        expected_q = {expected_q, one};
      end
    end
  endtask

  // Hold input until every pending output has left, then let the core settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [lrg_pkg::RATE_W-1:0] ir,
                          input logic [lrg_pkg::RATE_W-1:0] orr,
                          input logic [lrg_pkg::RATE_W-1:0] g);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= lrg_pkg::REG_IN_RATE;
    cfg_wdata <= ir;
    @(posedge clk);
    cfg_index <= lrg_pkg::REG_OUT_RATE;
    cfg_wdata <= orr;
    @(posedge clk);
    cfg_index <= lrg_pkg::REG_GAIN;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    in_rate_q  = ir;
    out_rate_q = orr;
    gain_q     = g;
  endtask

  always @(posedge clk) begin
    pcm_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected output beat: sample %0d last %0b",
                   $signed(m_axis_tdata), m_axis_tlast);
        mismatch_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tlast !== want.tail) begin
          if (mismatch_cnt < 10)
            $display("output mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                     want.value, want.tail, $signed(m_axis_tdata), m_axis_tlast);
          mismatch_cnt++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    int          ir;
    int          orr;
    int          g;
    int          lim;
    int          len;
    int          sent;
    logic [15:0] smp;
    logic        lst;

    // reset defaults: a lone first sample yields nothing, the next one
    // reproduces the previous sample exactly
    add_beat(16'sh7FFF, 1'b0, 0, 16'sh0000, 16'sh0000);
    add_beat(16'sh8000, 1'b0, 1, 16'sh7FFF, 16'sh0000);
    add_beat(16'sh0000, 1'b1, BY_MODEL, 16'sh0000, 16'sh0000);
    add_beat(-16'sd1, 1'b1, 0, 16'sh0000, 16'sh0000);
    // zero gain silences everything
    add_cfg(17'd22050, 17'd16000, 17'd0);
    add_beat(16'sd12345, 1'b0, 0, 16'sh0000, 16'sh0000);
    add_beat(-16'sd12345, 1'b0, 1, 16'sh0000, 16'sh0000);
    add_beat(16'sd1, 1'b1, BY_MODEL, 16'sh0000, 16'sh0000);
    // half gain truncates toward zero
    add_cfg(17'd22050, 17'd16000, 17'd32768);
    add_beat(-16'sd3, 1'b0, 0, 16'sh0000, 16'sh0000);
    add_beat(16'sd3, 1'b0, 1, -16'sd1, 16'sh0000);
    add_beat(16'sh7FFF, 1'b1, BY_MODEL, 16'sh0000, 16'sh0000);
    // zero rates act as one, gain above unity acts as unity
    add_cfg(17'd0, 17'd0, 17'h1FFFF);
    add_beat(16'sh7FFF, 1'b0, 0, 16'sh0000, 16'sh0000);
    add_beat(16'sh8000, 1'b0, 1, 16'sh7FFF, 16'sh0000);
    add_beat(16'sd5, 1'b1, 2, 16'sh8000, 16'sd5);
    // ratio far above four: output cap and phase skip
    add_cfg(17'd1000, 17'd96000, 17'd65535);
    add_beat(16'sd100, 1'b0, 0, 16'sh0000, 16'sh0000);
    add_beat(-16'sd100, 1'b0, BY_MODEL, 16'sh0000, 16'sh0000);
    add_beat(16'sd7, 1'b0, BY_MODEL, 16'sh0000, 16'sh0000);
    add_beat(16'sd0, 1'b1, BY_MODEL, 16'sh0000, 16'sh0000);
    // heavy decimation
    add_cfg(17'd96000, 17'd1000, 17'd65536);
    add_beat(16'sd1000, 1'b0, BY_MODEL, 16'sh0000, 16'sh0000);
    add_beat(-16'sd1000, 1'b0, BY_MODEL, 16'sh0000, 16'sh0000);
    add_beat(16'sh7FFF, 1'b0, BY_MODEL, 16'sh0000, 16'sh0000);
    add_beat(16'sh8000, 1'b1, BY_MODEL, 16'sh0000, 16'sh0000);
    // full-scale rates, smallest gain
    add_cfg(17'h1FFFF, 17'h1FFFF, 17'd1);
    add_beat(16'sh8000, 1'b0, BY_MODEL, 16'sh0000, 16'sh0000);
    add_beat(16'sh7FFF, 1'b1, BY_MODEL, 16'sh0000, 16'sh0000);
    // ratio exactly four
    add_cfg(17'd24000, 17'd96000, 17'd65535);
    add_beat(16'sh7FFF, 1'b0, BY_MODEL, 16'sh0000, 16'sh0000);
    add_beat(16'sh8000, 1'b1, BY_MODEL, 16'sh0000, 16'sh0000);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        set_regs(dir_tab[i].in_r, dir_tab[i].out_r, dir_tab[i].gn);
      end else begin
        send_sample(dir_tab[i].smp, dir_tab[i].lst, dir_tab[i].n_typed,
                    dir_tab[i].v0, dir_tab[i].v1);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        4: begin
          ir  = $urandom_range(1000, 20000);
          orr = $urandom_range(4 * ir + 1, 131071);
        end
        5: begin
          ir  = $urandom_range(50000, 131071);
          orr = $urandom_range(1000, 10000);
        end
        default: begin
          ir  = $urandom_range(1000, 96000);
          lim = (4 * ir > 96000) ? 96000 : 4 * ir;
          orr = $urandom_range(1000, lim);
        end
      endcase
      case ($urandom_range(3))
        0:       g = 65536;
        1:       g = $urandom_range(0, 65535);
        2:       g = $urandom_range(65537, 131071);
        default: g = $urandom_range(30000, 65536);
      endcase
      set_regs(17'(ir), 17'(orr), 17'(g));
      src_idle_pct   = src_mode[ph];
      sink_stall_pct = sink_mode[ph];
      sent = 0;
      while (sent < ITEMS_PER_PH) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
        for (int j = 0; j < len; j++) begin
          smp = ($urandom_range(5) == 0) ? rail_vals[$urandom_range(3)] : 16'($urandom);
          // a stray close now and then cuts the chunk short
          lst = (j == len - 1) || ($urandom_range(19) == 0);
          send_sample(smp, lst, BY_MODEL, 16'sh0000, 16'sh0000);
          sent++;
          if (ph == 3 && sent == ITEMS_PER_PH / 2) drain();
        end
      end
    end

    drain();
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> linear_resampler_with_gain_core.f
design/lrg_pkg.sv
design/lrg_fifo.sv
design/lrg_front.sv
design/lrg_div.sv
design/lrg_back.sv
design/linear_resampler_with_gain_core.sv
tb/tb_linear_resampler_with_gain_core.sv
